// ===== design/gsls_pkg.sv =====
// ----------------------------------------------------------------------------
// gsls_pkg
// Shared types, constants and helpers of the Gauss-Seidel linear solver.
// ----------------------------------------------------------------------------
package gsls_pkg;

  typedef struct packed {
    logic [3:0]         row;
    logic [3:0]         column;
    logic               is_rhs;
    logic signed [15:0] element;
    logic               start_solve;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         unknown_index;
    logic signed [47:0] solution;
    logic [1:0]         status;
    logic [15:0]        sweeps_used;
    logic               last;
  } res_t;

  typedef enum logic [4:0] {
    S_LOAD, S_INIT, S_DG_RD, S_DG_CHK, S_ROW, S_JRD, S_MLO, S_MHI, S_PROD,
    S_ACC, S_RHS_RD, S_NUM, S_DIV, S_QUO, S_WB, S_SWEEP, S_OUT_RD, S_OUT
  } state_e;

  localparam logic [1:0] CFG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_SWEEP = 2'd2;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  localparam int unsigned CFG_W  = 25;
  localparam int unsigned DIV_STEPS = 63;

  localparam logic [47:0] ONE_Q24 = 48'h0000_0100_0000;
  localparam logic [47:0] SOL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SOL_MIN = 48'h8000_0000_0000;
  localparam logic [63:0] ACC_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ACC_MIN = 64'h8000_0000_0000_0001;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (!s[64] && s[63]) begin
      return ACC_MAX;
    end else if (s[64] && (!s[63] || (s[62:0] == 63'd0))) begin
      return ACC_MIN;
    end else begin
      return s[63:0];
    end
  endfunction

endpackage

// ===== design/gsls_ram.sv =====
// ----------------------------------------------------------------------------
// gsls_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsls_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/gauss_seidel_linear_solver.sv =====
// Solve: the element with start_solve starts setup (solution RAM set to 1.0 and the
//   diagonal check), then the sweeps (skipped on a zero diagonal) and the output of n results.
// Throughput: loading takes a beat every cycle while busy is low; solve speed is set by
//   the 63-step divider and the shared multiply-accumulate that walks each row of the RAM.
// Results appear as separate beats on done_o, never back to back; the receiver cannot stall.
// Reset: rst_ni resets control and sets the configuration to its defaults; memories are not cleared.
// ----------------------------------------------------------------------------
// gauss_seidel_linear_solver
// Loads a linear system into RAM and solves it with Gauss-Seidel sweeps.
// ----------------------------------------------------------------------------
module gauss_seidel_linear_solver #(
  parameter int unsigned N_MAX = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  gsls_pkg::cmd_t             cmd_i,
  output logic                       done_o,
  output gsls_pkg::res_t             res_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [gsls_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned IW  = $clog2(N_MAX + 1);
  localparam int unsigned IA  = $clog2(N_MAX);
  localparam int unsigned CAW = $clog2(N_MAX * N_MAX);

  gsls_pkg::state_e state_q, state_d;

  logic [3:0]  size_q;
  logic [24:0] tol_q;
  logic [15:0] max_q;

  logic [IW-1:0]  n_q, i_q, j_q;
  logic [CAW-1:0] rb_q;
  logic           zero_q, within_q;
  logic [1:0]     status_q;
  logic [15:0]    count_q;
  logic signed [40:0] p_lo_q;
  logic signed [39:0] p_hi_q;
  logic [63:0]    prod_q, acc_q;
  logic [62:0]    quo_q;
  logic [16:0]    rem_q;
  logic [15:0]    dvs_q;
  logic           neg_q;
  logic [5:0]     cnt_q;
  logic [47:0]    prev_q, next_q;
  logic           done_q;
  gsls_pkg::res_t res_q;

  logic           coef_we, rhs_we, sol_we;
  logic [CAW-1:0] coef_waddr, coef_raddr;
  logic [IA-1:0]  sol_waddr, sol_raddr, rhs_waddr;
  logic [47:0]    sol_wdata;
  logic [15:0]    coef_rdata, rhs_rdata;
  logic [47:0]    sol_rdata;

  logic           accept, i_last, j_last, zero_now;
  logic [15:0]    count_inc;
  logic [4:0]     row_ext, col_ext;
  logic [63:0]    num;
  logic [16:0]    rem_sh;
  logic [48:0]    diff, diff_abs;
  logic [IW-1:0]  n_new;

  assign accept    = start && !busy;
  assign i_last    = (i_q == IW'(n_q - 1'b1));
  assign j_last    = (j_q == IW'(n_q - 1'b1));
  assign zero_now  = zero_q || (coef_rdata == 16'd0);
  assign count_inc = count_q + 16'd1;
  assign row_ext   = {1'b0, cmd_i.row};
  assign col_ext   = {1'b0, cmd_i.column};
  assign num       = gsls_pkg::sat_add({{24{rhs_rdata[15]}}, rhs_rdata, 24'd0}, -acc_q);
  assign rem_sh    = {rem_q[15:0], quo_q[62]};
  assign diff      = {next_q[47], next_q} - {prev_q[47], prev_q};
  assign diff_abs  = diff[48] ? -diff : diff;

  always_comb begin
    if (size_q < 4'd2) begin
      n_new = IW'(2);
    end else if ({1'b0, size_q} > 5'(N_MAX)) begin
      n_new = IW'(N_MAX);
    end else begin
      n_new = IW'(size_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gsls_pkg::S_LOAD:   if (accept && cmd_i.start_solve) state_d = gsls_pkg::S_INIT;
      gsls_pkg::S_INIT:   if (j_q == IW'(N_MAX - 1)) state_d = gsls_pkg::S_DG_RD;
      gsls_pkg::S_DG_RD:  state_d = gsls_pkg::S_DG_CHK;
      gsls_pkg::S_DG_CHK: begin
        if (!i_last) state_d = gsls_pkg::S_DG_RD;
        else if (zero_now) state_d = gsls_pkg::S_OUT_RD;
        else state_d = gsls_pkg::S_ROW;
      end
      gsls_pkg::S_ROW:    state_d = gsls_pkg::S_JRD;
      gsls_pkg::S_JRD:    state_d = gsls_pkg::S_MLO;
      gsls_pkg::S_MLO: begin
        if (j_q != i_q) state_d = gsls_pkg::S_MHI;
        else if (j_last) state_d = gsls_pkg::S_RHS_RD;
        else state_d = gsls_pkg::S_JRD;
      end
      gsls_pkg::S_MHI:    state_d = gsls_pkg::S_PROD;
      gsls_pkg::S_PROD:   state_d = gsls_pkg::S_ACC;
      gsls_pkg::S_ACC:    state_d = j_last ? gsls_pkg::S_RHS_RD : gsls_pkg::S_JRD;
      gsls_pkg::S_RHS_RD: state_d = gsls_pkg::S_NUM;
      gsls_pkg::S_NUM:    state_d = gsls_pkg::S_DIV;
      gsls_pkg::S_DIV:    if (cnt_q == 6'd0) state_d = gsls_pkg::S_QUO;
      gsls_pkg::S_QUO:    state_d = gsls_pkg::S_WB;
      gsls_pkg::S_WB:     state_d = i_last ? gsls_pkg::S_SWEEP : gsls_pkg::S_ROW;
      gsls_pkg::S_SWEEP: begin
        if (within_q || (count_inc >= max_q)) state_d = gsls_pkg::S_OUT_RD;
        else state_d = gsls_pkg::S_ROW;
      end
      gsls_pkg::S_OUT_RD: state_d = gsls_pkg::S_OUT;
      gsls_pkg::S_OUT:    state_d = i_last ? gsls_pkg::S_LOAD : gsls_pkg::S_OUT_RD;
      default:            state_d = gsls_pkg::S_LOAD;
    endcase
  end

  // outputs and memory control
  always_comb begin
    busy       = (state_q != gsls_pkg::S_LOAD);
    coef_we    = 1'b0;
    rhs_we     = 1'b0;
    sol_we     = 1'b0;
    coef_waddr = CAW'(row_ext) * CAW'(N_MAX) + CAW'(col_ext);
    rhs_waddr  = IA'(cmd_i.row);
    sol_waddr  = IA'(i_q);
    sol_wdata  = next_q;
    coef_raddr = rb_q + CAW'(j_q);
    sol_raddr  = IA'(j_q);
    case (state_q)
      gsls_pkg::S_LOAD: begin
        if (accept) begin
          if (cmd_i.is_rhs) begin
            rhs_we = (row_ext < 5'(N_MAX));
          end else begin
            coef_we = (row_ext < 5'(N_MAX)) && (col_ext < 5'(N_MAX));
          end
        end
      end
      gsls_pkg::S_INIT: begin
        sol_we    = 1'b1;
        sol_waddr = IA'(j_q);
        sol_wdata = gsls_pkg::ONE_Q24;
      end
      gsls_pkg::S_DG_RD, gsls_pkg::S_RHS_RD: begin
        coef_raddr = rb_q + CAW'(i_q);
        sol_raddr  = IA'(i_q);
      end
      gsls_pkg::S_OUT_RD: sol_raddr = IA'(i_q);
      gsls_pkg::S_WB:     sol_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gsls_pkg::S_LOAD;
      size_q  <= 4'd2;
      tol_q   <= 25'd1;
      max_q   <= 16'd1000;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == gsls_pkg::S_OUT);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gsls_pkg::CFG_SIZE:  size_q <= cfg_wdata_i[3:0];
          gsls_pkg::CFG_TOL:   tol_q  <= cfg_wdata_i[24:0];
          gsls_pkg::CFG_SWEEP: max_q  <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gsls_pkg::S_LOAD: begin
        n_q      <= n_new;
        j_q      <= '0;
        count_q  <= 16'd0;
        status_q <= gsls_pkg::ST_CONVERGED;
        zero_q   <= 1'b0;
      end
      gsls_pkg::S_INIT: begin
        j_q <= j_q + 1'b1;
        i_q  <= '0;
        rb_q <= '0;
      end
      gsls_pkg::S_DG_CHK: begin
        zero_q <= zero_now;
        if (i_last) begin
          i_q      <= '0;
          rb_q     <= '0;
          within_q <= 1'b1;
          if (zero_now) status_q <= gsls_pkg::ST_ZERO_DIAG;
        end else begin
          i_q  <= i_q + 1'b1;
          rb_q <= rb_q + CAW'(N_MAX);
        end
      end
      gsls_pkg::S_ROW: begin
        j_q   <= '0;
        acc_q <= 64'd0;
      end
      gsls_pkg::S_MLO: begin
        p_lo_q <= $signed(coef_rdata) * $signed({1'b0, sol_rdata[23:0]});
        if (j_q == i_q) j_q <= j_q + 1'b1;
      end
      gsls_pkg::S_MHI:  p_hi_q <= $signed(coef_rdata) * $signed(sol_rdata[47:24]);
      gsls_pkg::S_PROD: prod_q <= {p_hi_q, 24'd0} + {{23{p_lo_q[40]}}, p_lo_q};
      gsls_pkg::S_ACC: begin
        acc_q <= gsls_pkg::sat_add(acc_q, prod_q);
        j_q   <= j_q + 1'b1;
      end
      gsls_pkg::S_NUM: begin
        neg_q  <= num[63] ^ coef_rdata[15];
        quo_q  <= num[63] ? 63'(-num) : num[62:0];
        rem_q  <= 17'd0;
        dvs_q  <= coef_rdata[15] ? -coef_rdata : coef_rdata;
        prev_q <= sol_rdata;
        cnt_q  <= 6'(gsls_pkg::DIV_STEPS - 1);
      end
      gsls_pkg::S_DIV: begin
        cnt_q <= cnt_q - 6'd1;
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_q <= rem_sh - {1'b0, dvs_q};
          quo_q <= {quo_q[61:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[61:0], 1'b0};
        end
      end
      gsls_pkg::S_QUO: begin
        if (!neg_q) begin
          next_q <= (quo_q > 63'(gsls_pkg::SOL_MAX)) ? gsls_pkg::SOL_MAX : quo_q[47:0];
        end else begin
          next_q <= (quo_q > 63'(gsls_pkg::SOL_MIN)) ? gsls_pkg::SOL_MIN : -quo_q[47:0];
        end
      end
      gsls_pkg::S_WB: begin
        if (diff_abs > 49'(tol_q)) within_q <= 1'b0;
        if (i_last) begin
          i_q  <= '0;
          rb_q <= '0;
        end else begin
          i_q  <= i_q + 1'b1;
          rb_q <= rb_q + CAW'(N_MAX);
        end
      end
      gsls_pkg::S_SWEEP: begin
        count_q  <= count_inc;
        within_q <= 1'b1;
        if (!within_q && (count_inc >= max_q)) status_q <= gsls_pkg::ST_LIMIT;
      end
      gsls_pkg::S_OUT: begin
        res_q.unknown_index <= 4'(i_q);
        res_q.solution      <= sol_rdata;
        res_q.status        <= status_q;
        res_q.sweeps_used   <= count_q;
        res_q.last          <= i_last;
        i_q                 <= i_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  gsls_ram #(.WIDTH(16), .DEPTH(N_MAX * N_MAX)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (cmd_i.element),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  gsls_ram #(.WIDTH(16), .DEPTH(N_MAX)) u_rhs_ram (
    .clk_i   (clk_i),
    .we_i    (rhs_we),
    .waddr_i (rhs_waddr),
    .wdata_i (cmd_i.element),
    .raddr_i (IA'(i_q)),
    .rdata_o (rhs_rdata)
  );

  gsls_ram #(.WIDTH(48), .DEPTH(N_MAX)) u_sol_ram (
    .clk_i   (clk_i),
    .we_i    (sol_we),
    .waddr_i (sol_waddr),
    .wdata_i (sol_wdata),
    .raddr_i (sol_raddr),
    .rdata_o (sol_rdata)
  );

endmodule

// ===== design/gsls_checker.sv =====
// ----------------------------------------------------------------------------
// gsls_checker
// Port-level checks of the solver's command and result behavior.
// ----------------------------------------------------------------------------
module gsls_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input gsls_pkg::cmd_t cmd_i,
  input logic           done_o,
  input gsls_pkg::res_t res_o
);

  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.start_solve |=> busy)
    else $error("solve start did not raise busy");

  a_beat_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat outside a solve");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.last |=> !done_o)
    else $error("beat after last result");

  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && done_o |-> res_o.last)
    else $error("non-final beat while idle");

endmodule

bind gauss_seidel_linear_solver gsls_checker u_gsls_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .res_o  (res_o)
);
